// ===== hdl/sgto_pkg.sv =====
// package for the scaled glyph text overlay
// glyph bitmaps, register indexes, reset values and colour packing; no dependencies
`timescale 1ns / 1ps

package sgto_pkg;

    localparam int MAX_CHARS_DEF = 8;
    localparam int GLYPH_COLUMNS = 3;
    localparam int GLYPH_ROWS    = 5;
    localparam int GLYPH_COUNT   = 12;

    localparam logic [2:0] CFG_TEXT_CHARS  = 3'd0;
    localparam logic [2:0] CFG_TEXT_LENGTH = 3'd1;
    localparam logic [2:0] CFG_SCREEN_W    = 3'd2;
    localparam logic [2:0] CFG_SCREEN_H    = 3'd3;
    localparam logic [2:0] CFG_DEPTH_MODE  = 3'd4;
    localparam logic [2:0] CFG_FG_RGB      = 3'd5;
    localparam logic [2:0] CFG_BG_RGB      = 3'd6;

    localparam logic [11:0] RST_SCREEN_W = 12'd640;
    localparam logic [11:0] RST_SCREEN_H = 12'd480;
    localparam logic [23:0] RST_FG_RGB   = 24'h26C281;
    localparam logic [23:0] RST_BG_RGB   = 24'h202020;

    localparam logic [3:0] GLYPH_COLON = 4'd10;
    localparam logic [3:0] GLYPH_BLANK = 4'd11;

    typedef logic [GLYPH_COLUMNS-1:0] t_glyph_row;
    typedef t_glyph_row t_glyph[GLYPH_ROWS];

    localparam t_glyph GLYPHS [GLYPH_COUNT] = '{
        '{3'h7, 3'h5, 3'h5, 3'h5, 3'h7},
        '{3'h2, 3'h6, 3'h2, 3'h2, 3'h7},
        '{3'h7, 3'h1, 3'h7, 3'h4, 3'h7},
        '{3'h7, 3'h1, 3'h7, 3'h1, 3'h7},
        '{3'h5, 3'h5, 3'h7, 3'h1, 3'h1},
        '{3'h7, 3'h4, 3'h7, 3'h1, 3'h7},
        '{3'h7, 3'h4, 3'h7, 3'h5, 3'h7},
        '{3'h7, 3'h1, 3'h2, 3'h2, 3'h2},
        '{3'h7, 3'h5, 3'h7, 3'h5, 3'h7},
        '{3'h7, 3'h5, 3'h7, 3'h1, 3'h7},
        '{3'h0, 3'h2, 3'h0, 3'h2, 3'h0},
        '{3'h0, 3'h0, 3'h0, 3'h0, 3'h0}
    };

    function automatic t_glyph_row glyph_row(input logic [7:0] code, input logic [2:0] row);
        logic [3:0] gi;
        if (code >= 8'h30 && code <= 8'h39) begin
            gi = 4'(code - 8'h30);
        end else if (code == 8'h3A) begin
            gi = GLYPH_COLON;
        end else begin
            gi = GLYPH_BLANK;
        end
        if (row < 3'(GLYPH_ROWS)) begin
            glyph_row = GLYPHS[gi][row];
        end else begin
            glyph_row = '0;
        end
    endfunction

    function automatic logic [23:0] pack_rgb(input logic [23:0] rgb, input logic mode);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = rgb[23:16];
        g = rgb[15:8];
        b = rgb[7:0];
        if (mode) begin
            pack_rgb = {b, g, r};
        end else begin
            pack_rgb = {8'h00, r[7:3], g[7:2], b[7:3]};
        end
    endfunction

endpackage

// ===== hdl/scaled_glyph_text_overlay_core.sv =====
// scaled glyph text overlay: pixel colour pipeline and layout sequencer
// depends on sgto_pkg
`timescale 1ns / 1ps

// Use: a pixel request (i_pixel_x, i_pixel_y) enters on i_valid while o_stall is
// low; its packed colour leaves on o_valid with o_pixel_value and o_write_enable,
// taken while i_stall is low. Registers are written on the i_cfg_valid/o_cfg_ready
// port with a register index and data; write only while no request is in flight.
// A request passes the five-register compare/lookup pipeline on its way to
// o_valid; one request per cycle is accepted back to back while o_stall is low.
// After reset and after every register write, a layout sequencer works out scale,
// origin and glyph cell bounds with a one-bit-per-cycle divider: a divide for the
// scale, a width check, at most one more divide, then origin and cell bounds.
// During that time o_stall is high and no request is accepted.
// Reset clears the pipeline valid bits, loads the default registers (640x480,
// 24-bit colour, empty text) and starts the sequencer.
// When the receiver holds i_stall, results stay in the output register and the
// stages behind fill up; o_stall rises once stage one cannot move on. Nothing is
// dropped or repeated.
module scaled_glyph_text_overlay_core #(
    parameter int MAX_CHARS = sgto_pkg::MAX_CHARS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [11:0] i_pixel_x,
    input  logic [11:0] i_pixel_y,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [23:0] o_pixel_value,
    output logic        o_write_enable,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import sgto_pkg::*;

    localparam int CIW = $clog2(MAX_CHARS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_GEOM = 3'd3;
    localparam logic [2:0] ST_BND  = 3'd4;

    localparam logic [1:0] JOB_SCALE  = 2'd0;
    localparam logic [1:0] JOB_SHRINK = 2'd2;

    // registers
    logic [63:0] r_chars;
    logic [3:0]  r_len;
    logic [11:0] r_w;
    logic [11:0] r_h;
    logic        r_mode;
    logic [23:0] r_fg;
    logic [23:0] r_bg;

    // layout
    logic [2:0]  r_state;
    logic [1:0]  r_job;
    logic [11:0] r_rem;
    logic [11:0] r_quo;
    logic [11:0] r_den;
    logic [3:0]  r_dcnt;
    logic        r_shrunk;
    logic [11:0] r_scale;
    logic [16:0] r_total;
    logic [11:0] r_ox;
    logic [11:0] r_oy;
    logic [14:0] r_charh;
    logic [13:0] r_pitch;
    logic [13:0] r_s2;
    logic [13:0] r_s3;
    logic [13:0] r_s4;
    logic [16:0] r_acc;
    logic [CIW-1:0] r_bcnt;
    logic [16:0] r_xb [MAX_CHARS+1];

    logic [3:0]  len_sat;
    logic [3:0]  len_eff;
    logic [4:0]  span;
    logic [12:0] dv_sh;
    logic        dv_ge;
    logic [11:0] dv_rem;
    logic [11:0] dv_quo;
    logic [11:0] s_pick;
    logic [16:0] prod;
    logic [16:0] n_acc;
    logic [25:0] maxh_prod;
    logic [11:0] maxh;

    assign len_sat = (r_len > 4'(MAX_CHARS)) ? 4'(MAX_CHARS) : r_len;
    assign len_eff = (len_sat == 4'd0) ? 4'd1 : len_sat;
    assign span    = 5'({2'b00, len_eff} * 6'd4 - 6'd1);
    assign dv_sh   = {r_rem, r_quo[11]};
    assign dv_ge   = dv_sh >= {1'b0, r_den};
    assign dv_rem  = dv_ge ? 12'(dv_sh - {1'b0, r_den}) : dv_sh[11:0];
    assign dv_quo  = {r_quo[10:0], dv_ge};
    assign prod    = 17'(r_scale * span);
    assign n_acc   = r_acc + {3'b000, r_pitch};

    // height over seven by reciprocal multiply
    assign maxh_prod = {14'b0, r_h} * 26'd9363;
    assign maxh      = {2'b00, maxh_prod[25:16]};

    always_comb begin
        s_pick = dv_quo;
        if (dv_quo == 12'd0 || dv_quo > maxh) begin
            s_pick = maxh;
        end
        if (s_pick == 12'd0) begin
            s_pick = 12'd1;
        end
    end

    logic cfg_wr;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chars <= '0;
            r_len   <= '0;
            r_w     <= RST_SCREEN_W;
            r_h     <= RST_SCREEN_H;
            r_mode  <= 1'b1;
            r_fg    <= RST_FG_RGB;
            r_bg    <= RST_BG_RGB;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_TEXT_CHARS:  r_chars <= i_cfg_data;
                CFG_TEXT_LENGTH: r_len   <= i_cfg_data[3:0];
                CFG_SCREEN_W:    r_w     <= i_cfg_data[11:0];
                CFG_SCREEN_H:    r_h     <= i_cfg_data[11:0];
                CFG_DEPTH_MODE:  r_mode  <= i_cfg_data[0];
                CFG_FG_RGB:      r_fg    <= i_cfg_data[23:0];
                CFG_BG_RGB:      r_bg    <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // layout sequencer; restarts on reset and on every register write
    logic r_start;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_start <= 1'b1;
        end else if (cfg_wr) begin
            r_state <= ST_IDLE;
            r_start <= 1'b1;
        end else if (r_start) begin
            r_start  <= 1'b0;
            r_state  <= ST_DIV;
            r_job    <= JOB_SCALE;
            r_rem    <= '0;
            r_quo    <= r_w;
            r_den    <= 12'({len_eff, 2'b00});
            r_dcnt   <= '0;
            r_shrunk <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: ;
                ST_DIV: begin
                    r_rem  <= dv_rem;
                    r_quo  <= dv_quo;
                    r_dcnt <= r_dcnt + 4'd1;
                    if (r_dcnt == 4'd11) begin
                        r_dcnt <= '0;
                        r_rem  <= '0;
                        unique case (r_job)
                            JOB_SCALE: begin
                                r_scale <= s_pick;
                                r_state <= ST_CHK;
                            end
                            default: begin
                                r_scale <= (dv_quo == 12'd0) ? 12'd1 : dv_quo;
                                r_state <= ST_CHK;
                            end
                        endcase
                    end
                end
                ST_CHK: begin
                    r_total <= prod;
                    if (prod > {5'b0, r_w} && !r_shrunk) begin
                        r_shrunk <= 1'b1;
                        r_job    <= JOB_SHRINK;
                        r_quo    <= r_w;
                        r_den    <= {7'b0, span};
                        r_state  <= ST_DIV;
                    end else begin
                        r_state <= ST_GEOM;
                    end
                end
                ST_GEOM: begin
                    r_ox    <= ({5'b0, r_w} > r_total) ? 12'((17'(r_w) - r_total) >> 1) : '0;
                    r_charh <= 15'({r_scale, 2'b00}) + 15'(r_scale);
                    r_pitch <= {r_scale, 2'b00};
                    r_s2    <= {1'b0, r_scale, 1'b0};
                    r_s3    <= 14'({r_scale, 1'b0}) + 14'(r_scale);
                    r_s4    <= {r_scale, 2'b00};
                    r_acc   <= '0;
                    r_bcnt  <= CIW'(1);
                    r_state <= ST_BND;
                end
                ST_BND: begin
                    r_oy    <= ({3'b0, r_h} > r_charh) ? 12'((15'(r_h) - r_charh) >> 1) : '0;
                    r_acc   <= n_acc;
                    r_bcnt  <= r_bcnt + CIW'(1);
                    if (r_bcnt == CIW'(MAX_CHARS)) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_xb[0] <= '0;
        if (r_state == ST_BND) begin
            r_xb[r_bcnt] <= n_acc;
        end
    end

    // pixel pipeline
    logic busy;
    logic en1, en2, en3, en4, en5;
    logic accept;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    assign busy   = r_start || (r_state != ST_IDLE) || cfg_wr;
    assign en5    = !r_v5 || !i_stall;
    assign en4    = !r_v4 || en5;
    assign en3    = !r_v3 || en4;
    assign en2    = !r_v2 || en3;
    assign en1    = !r_v1 || en2;
    assign o_stall = busy || !en1;
    assign accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= accept;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    // stage 1: capture
    logic [11:0] r1_x, r1_y;
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_x <= i_pixel_x;
            r1_y <= i_pixel_y;
        end
    end

    // stage 2: screen and text box checks
    logic [11:0] r2_dx, r2_dy;
    logic        r2_on, r2_in;
    logic [11:0] dy2;
    assign dy2 = r1_y - r_oy;
    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_on <= (len_sat != 4'd0) && (r1_x < r_w) && (r1_y < r_h);
            r2_in <= (r1_x >= r_ox) && (r1_y >= r_oy) && ({3'b0, dy2} < r_charh);
            r2_dx <= r1_x - r_ox;
            r2_dy <= dy2;
        end
    end

    // stage 3: character index and glyph row
    logic [CIW-1:0] ci3;
    logic [2:0]     row3;
    logic [CIW-1:0] r3_ci;
    logic [2:0]     r3_row;
    logic [11:0]    r3_dx;
    logic           r3_on, r3_in;
    always_comb begin
        ci3 = '0;
        for (int k = 1; k <= MAX_CHARS; k++) begin
            if (r_xb[k] <= {5'b0, r2_dx}) begin
                ci3 = ci3 + CIW'(1);
            end
        end
        row3 = 3'(r2_dy >= r_scale) + 3'({2'b0, r2_dy} >= r_s2)
             + 3'({2'b0, r2_dy} >= r_s3) + 3'({2'b0, r2_dy} >= r_s4);
    end
    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_ci  <= ci3;
            r3_row <= row3;
            r3_dx  <= r2_dx;
            r3_on  <= r2_on;
            r3_in  <= r2_in;
        end
    end

    // stage 4: offset in the cell and glyph lookup
    logic [63:0]      chars4;
    logic [11:0]      r4_within;
    t_glyph_row       r4_bits;
    logic             r4_ok, r4_on;
    assign chars4 = r_chars >> {r3_ci, 3'b000};
    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_within <= 12'({5'b0, r3_dx} - r_xb[r3_ci]);
            r4_bits   <= glyph_row(chars4[7:0], r3_row);
            r4_ok     <= r3_in && ({{(4-CIW+1){1'b0}}, r3_ci} < {1'b0, len_sat});
            r4_on     <= r3_on;
        end
    end

    // stage 5: column select and colour packing
    logic [1:0] col5;
    logic       lit5;
    assign col5 = 2'(r4_within >= r_scale) + 2'({2'b0, r4_within} >= r_s2);
    assign lit5 = r4_ok && ({2'b0, r4_within} < r_s3) && r4_bits[2'd2 - col5];
    always_ff @(posedge i_clk) begin
        if (en5) begin
            o_pixel_value  <= r4_on ? pack_rgb(lit5 ? r_fg : r_bg, r_mode) : '0;
            o_write_enable <= r4_on;
        end
    end
    assign o_valid = r_v5;

`ifndef NO_ASSERTIONS
    a_scale_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && !r_start) |-> (r_scale != 12'd0))
        else $error("layout finished with zero scale");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall)
        else $error("request accepted during layout");
    a_blank_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_write_enable) |-> (o_pixel_value == 24'd0))
        else $error("unwritten pixel carries colour");
    a_lit_in_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && r4_ok && r4_bits != '0) |-> (r4_within < 12'(r_xb[1])))
        else $error("cell offset beyond pitch");
`endif

endmodule
